FILE: rtl/acs_pkg.sv
// acs_pkg: shared types, widths and codes for the attitude calibrate and smooth block.
// Used by every module in rtl/; depends on nothing.
package acs_pkg;

  localparam int ANGLE_W     = 16;
  localparam int GYRO_W      = 16;
  localparam int AXES        = 3;
  localparam int MOTION_W    = 17;  // |x|+|y|+|z| of three 16-bit rates
  localparam int ACC_W       = 29;  // still-sample angle accumulator
  localparam int CNT_W       = 16;  // sample counter
  localparam int WARMUP_W    = 16;
  localparam int CAL_W       = 13;
  localparam int THRESH_W    = 17;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 17;

  localparam int ANGLE_LIMIT = 23040;  // 180 deg in 1/128 deg

  localparam logic [WARMUP_W-1:0] WARMUP_DEF = WARMUP_W'(200);
  localparam logic [CAL_W-1:0]    CAL_DEF    = CAL_W'(100);
  localparam logic [THRESH_W-1:0] THRESH_DEF = THRESH_W'(80);

  localparam int WINDOW_DEPTH_DEF = 8;
  localparam int QUEUE_DEPTH_DEF  = 2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_WARMUP = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CAL    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESH = 2'd2;

  typedef enum logic [1:0] {
    PH_WARMUP  = 2'd0,
    PH_COLLECT = 2'd1,
    PH_CAL     = 2'd2
  } phase_t;

  typedef struct packed {
    logic signed [GYRO_W-1:0]  gyro_x;
    logic signed [GYRO_W-1:0]  gyro_y;
    logic signed [GYRO_W-1:0]  gyro_z;
    logic signed [ANGLE_W-1:0] roll_in;
    logic signed [ANGLE_W-1:0] pitch_in;
    logic signed [ANGLE_W-1:0] yaw_in;
  } in_word_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] avg_roll;
    logic signed [ANGLE_W-1:0] avg_pitch;
    logic signed [ANGLE_W-1:0] avg_yaw;
    logic signed [ANGLE_W-1:0] corrected_roll;
    logic signed [ANGLE_W-1:0] corrected_pitch;
    logic [1:0]                cal_phase;
  } out_word_t;

  // classified word held between front and back
  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] yaw;
    logic                      still;
  } q_entry_t;

  typedef struct packed {
    logic [WARMUP_W-1:0] warmup_samples;
    logic [CAL_W-1:0]    cal_samples;
  } phase_cfg_t;

endpackage

FILE: rtl/acs_front.sv
// acs_front: takes input words, classifies them as still or moving.
// Depends on acs_pkg; feeds acs_queue.
module acs_front import acs_pkg::*; (
  input  logic                in_valid,
  output logic                in_ready,
  input  in_word_t            in_data,
  input  logic [THRESH_W-1:0] still_threshold,
  input  logic                q_full,
  output logic                q_push,
  output q_entry_t            q_ent
);

  logic signed [MOTION_W-1:0] gx, gy, gz;
  logic [MOTION_W-1:0]        ax, ay, az, motion;

  always_comb begin
    gx = MOTION_W'(in_data.gyro_x);
    gy = MOTION_W'(in_data.gyro_y);
    gz = MOTION_W'(in_data.gyro_z);
    ax = (gx < 0) ? MOTION_W'(-gx) : MOTION_W'(gx);
    ay = (gy < 0) ? MOTION_W'(-gy) : MOTION_W'(gy);
    az = (gz < 0) ? MOTION_W'(-gz) : MOTION_W'(gz);
    motion = ax + ay + az;  // max 98304, fits
  end

  assign in_ready    = !q_full;
  assign q_push      = in_valid && !q_full;
  assign q_ent.roll  = in_data.roll_in;
  assign q_ent.pitch = in_data.pitch_in;
  assign q_ent.yaw   = in_data.yaw_in;
  assign q_ent.still = (motion <= MOTION_W'(still_threshold));

endmodule

FILE: rtl/acs_queue.sv
// acs_queue: short FIFO of classified words between front and back.
// Depends on acs_pkg.
module acs_queue import acs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_ent,
  output logic     full,
  input  logic     pop,
  output q_entry_t pop_ent,
  output logic     empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t       mem_r [DEPTH];
  logic [PW-1:0]  wr_r, rd_r;
  logic [CW-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_ent;
    end
  end

  assign pop_ent = mem_r[rd_r];
  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);

endmodule

FILE: rtl/acs_div.sv
// acs_div: restoring serial divider, one quotient bit per cycle, unsigned.
// Depends on acs_pkg for default widths.
module acs_div import acs_pkg::*; #(
  parameter int NW = ACC_W,
  parameter int DW = CNT_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quot
);

  localparam int CTW = $clog2(NW + 1);

  logic [CTW-1:0] cnt_r;
  logic [NW-1:0]  quot_r;
  logic [DW-1:0]  rem_r, den_r, rem_nxt;
  logic [DW:0]    shifted, diff;
  logic           ge;

  always_comb begin
    shifted = {rem_r, quot_r[NW-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
    rem_nxt = ge ? diff[DW-1:0] : shifted[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CTW'(NW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= num;
      den_r  <= den;
      rem_r  <= '0;
    end else if (cnt_r != '0) begin
      quot_r <= {quot_r[NW-2:0], ge};
      rem_r  <= rem_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign quot = quot_r;

endmodule

FILE: rtl/acs_back.sv
// acs_back: window means, calibration phases, offsets and output register.
// Depends on acs_pkg and acs_div; pops words from acs_queue.
module acs_back import acs_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  phase_cfg_t pcfg,
  input  logic       q_empty,
  input  q_entry_t   q_ent,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data
);

  localparam int SW  = ANGLE_W + $clog2(WINDOW_DEPTH);
  localparam int DPW = $clog2(WINDOW_DEPTH + 1);
  // floor(2^SW / depth): quotient estimate is exact or one low
  localparam logic [SW-1:0]  RECIP   = SW'((64'(1) << SW) / WINDOW_DEPTH);
  localparam logic [DPW-1:0] DEPTH_C = DPW'(WINDOW_DEPTH);
  localparam logic [SW-1:0]  DEPTH_S = SW'(WINDOW_DEPTH);
  localparam logic [SW-1:0]  TWO_D   = SW'(2 * WINDOW_DEPTH);
  localparam logic [SW-1:0]  LIM_S   = SW'(ANGLE_LIMIT);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_REM, S_FIX, S_DIV, S_OUT} state_t;

  state_t                    st_r;
  phase_t                    phase_r, phase_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt, cnt_inc;
  logic signed [ACC_W-1:0]   racc_r, pacc_r, racc_nxt, pacc_nxt;
  logic signed [ANGLE_W-1:0] roff_r, poff_r;
  logic                      div_go, div_pend_r, corr_en_r;
  logic                      out_valid_r;
  out_word_t                 out_word_r;

  logic signed [ANGLE_W-1:0] win_r [WINDOW_DEPTH][AXES];
  logic signed [ANGLE_W-1:0] new_ang [AXES];
  logic signed [SW-1:0]      sum_r [AXES];
  logic signed [SW-1:0]      sum_nxt [AXES];

  // reciprocal divide lanes, one per axis
  logic [SW-1:0]             mag_r [AXES];
  logic [AXES-1:0]           neg_r;
  logic [2*SW-1:0]           prod_r [AXES];
  logic [SW-1:0]             q0_r [AXES];
  logic [SW-1:0]             qd_r [AXES];
  logic [SW+DPW-1:0]         qd_full [AXES];
  logic [SW-1:0]             rem [AXES];
  logic [SW-1:0]             qfix [AXES];
  logic [SW-1:0]             qsat [AXES];
  logic signed [ANGLE_W-1:0] mean_r [AXES];
  logic signed [ANGLE_W-1:0] roll_r, pitch_r;

  // offset dividers
  logic [ACC_W-1:0]          rnum, pnum, rquot, pquot;
  logic                      rbusy, pbusy, div_busy;
  logic                      rneg_r, pneg_r;

  logic signed [ANGLE_W+1:0] croll, cpitch;

  function automatic logic signed [ANGLE_W-1:0] sat_diff(input logic signed [ANGLE_W+1:0] v);
    if (v > (ANGLE_W + 2)'(ANGLE_LIMIT)) begin
      return ANGLE_W'(ANGLE_LIMIT);
    end else if (v < -(ANGLE_W + 2)'(ANGLE_LIMIT)) begin
      return -ANGLE_W'(ANGLE_LIMIT);
    end
    return ANGLE_W'(v);
  endfunction

  assign new_ang[0] = q_ent.roll;
  assign new_ang[1] = q_ent.pitch;
  assign new_ang[2] = q_ent.yaw;

  assign q_pop = (st_r == S_IDLE) && !q_empty;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      sum_nxt[a] = sum_r[a] - SW'(win_r[0][a]) + SW'(new_ang[a]);
      qd_full[a] = prod_r[a][2*SW-1:SW] * DEPTH_C;
      rem[a]     = mag_r[a] - qd_r[a];
      qfix[a]    = q0_r[a] + SW'(rem[a] >= DEPTH_S);
      qsat[a]    = (qfix[a] > LIM_S) ? LIM_S : qfix[a];
    end
  end

  // calibration phase step for the word being popped
  always_comb begin
    cnt_inc   = cnt_r + 1'b1;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    racc_nxt  = racc_r;
    pacc_nxt  = pacc_r;
    div_go    = 1'b0;
    unique case (phase_r)
      PH_WARMUP: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= CNT_W'(pcfg.warmup_samples)) begin
          phase_nxt = PH_COLLECT;
          cnt_nxt   = '0;
        end
      end
      PH_COLLECT: begin
        if (!q_ent.still) begin
          cnt_nxt  = '0;
          racc_nxt = '0;
          pacc_nxt = '0;
        end else begin
          racc_nxt = racc_r + ACC_W'(q_ent.roll);
          pacc_nxt = pacc_r + ACC_W'(q_ent.pitch);
          cnt_nxt  = cnt_inc;
          if (cnt_inc >= CNT_W'(pcfg.cal_samples) && cnt_inc != '0) begin
            phase_nxt = PH_CAL;
            div_go    = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign rnum = (racc_nxt < 0) ? ACC_W'(-racc_nxt) : ACC_W'(racc_nxt);
  assign pnum = (pacc_nxt < 0) ? ACC_W'(-pacc_nxt) : ACC_W'(pacc_nxt);

  acs_div #(.NW(ACC_W), .DW(CNT_W)) u_div_roll (
    .clk   (clk),
    .rst_n (rst_n),
    .start (q_pop && div_go),
    .num   (rnum),
    .den   (cnt_inc),
    .busy  (rbusy),
    .quot  (rquot)
  );

  acs_div #(.NW(ACC_W), .DW(CNT_W)) u_div_pitch (
    .clk   (clk),
    .rst_n (rst_n),
    .start (q_pop && div_go),
    .num   (pnum),
    .den   (cnt_inc),
    .busy  (pbusy),
    .quot  (pquot)
  );

  assign div_busy = rbusy || pbusy;

  assign croll  = corr_en_r ? (ANGLE_W + 2)'(roll_r) - (ANGLE_W + 2)'(roff_r)
                            : (ANGLE_W + 2)'(roll_r);
  assign cpitch = corr_en_r ? (ANGLE_W + 2)'(pitch_r) - (ANGLE_W + 2)'(poff_r)
                            : (ANGLE_W + 2)'(pitch_r);

  // sequencer, calibration state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      phase_r     <= PH_WARMUP;
      cnt_r       <= '0;
      racc_r      <= '0;
      pacc_r      <= '0;
      roff_r      <= '0;
      poff_r      <= '0;
      div_pend_r  <= 1'b0;
      corr_en_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_word_r  <= '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        for (int a = 0; a < AXES; a++) begin
          win_r[i][a] <= '0;
        end
      end
      for (int a = 0; a < AXES; a++) begin
        sum_r[a] <= '0;
      end
    end else begin
      // S_OUT reloads the register itself when the old word leaves
      if (out_valid_r && out_ready && st_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
              for (int a = 0; a < AXES; a++) begin
                win_r[i][a] <= win_r[i+1][a];
              end
            end
            for (int a = 0; a < AXES; a++) begin
              win_r[WINDOW_DEPTH-1][a] <= new_ang[a];
              sum_r[a]                 <= sum_nxt[a];
            end
            corr_en_r  <= (phase_r == PH_CAL);
            phase_r    <= phase_nxt;
            cnt_r      <= cnt_nxt;
            racc_r     <= racc_nxt;
            pacc_r     <= pacc_nxt;
            div_pend_r <= div_go;
            st_r       <= S_MUL;
          end
        end
        S_MUL: st_r <= S_REM;
        S_REM: st_r <= S_FIX;
        S_FIX: st_r <= div_pend_r ? S_DIV : S_OUT;
        S_DIV: begin
          if (!div_busy) begin
            roff_r     <= ANGLE_W'(rneg_r ? -rquot : rquot);
            poff_r     <= ANGLE_W'(pneg_r ? -pquot : pquot);
            div_pend_r <= 1'b0;
            st_r       <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_word_r.avg_roll        <= mean_r[0];
            out_word_r.avg_pitch       <= mean_r[1];
            out_word_r.avg_yaw         <= mean_r[2];
            out_word_r.corrected_roll  <= sat_diff(croll);
            out_word_r.corrected_pitch <= sat_diff(cpitch);
            out_word_r.cal_phase       <= phase_r;
            out_valid_r                <= 1'b1;
            st_r                       <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      roll_r  <= q_ent.roll;
      pitch_r <= q_ent.pitch;
      rneg_r  <= (racc_nxt < 0);
      pneg_r  <= (pacc_nxt < 0);
      for (int a = 0; a < AXES; a++) begin
        neg_r[a] <= (sum_nxt[a] < 0);
        mag_r[a] <= (sum_nxt[a] < 0) ? SW'(-sum_nxt[a]) : SW'(sum_nxt[a]);
      end
    end
    for (int a = 0; a < AXES; a++) begin
      if (st_r == S_MUL) begin
        prod_r[a] <= mag_r[a] * RECIP;
      end
      if (st_r == S_REM) begin
        q0_r[a] <= prod_r[a][2*SW-1:SW];
      end
      if (st_r == S_FIX) begin
        mean_r[a] <= neg_r[a] ? -ANGLE_W'(qsat[a]) : ANGLE_W'(qsat[a]);
      end
    end
  end

  // q0 * depth is formed from the product in the same cycle q0 is loaded
  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      qd_r[a] <= qd_full[a][SW-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  a_cal_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CAL) |=> (phase_r == PH_CAL))
    else $error("calibrated phase left");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> !div_busy)
    else $error("offset divider busy while sequencer idle");

  a_pend_cal: assert property (@(posedge clk) disable iff (!rst_n)
    div_pend_r |-> (phase_r == PH_CAL))
    else $error("offset division pending outside calibrated phase");

  a_recip_err: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FIX) |-> (rem[0] < TWO_D && rem[1] < TWO_D && rem[2] < TWO_D))
    else $error("reciprocal quotient estimate off by more than one");

endmodule

FILE: rtl/attitude_calibrate_and_smooth.sv
// attitude_calibrate_and_smooth: top level, configuration registers and wiring.
// Depends on acs_pkg, acs_front, acs_queue, acs_back (and acs_div below it).
//
// Takes one word per sample carrying three gyro rates (1/16 deg/s) and the
// roll, pitch and yaw angles (1/128 deg) from an attitude filter, and returns
// one word per sample: moving averages of the three raw angles over the last
// WINDOW_DEPTH samples (window is zero after reset, mean truncated toward zero,
// saturated to +/-180 deg), roll and pitch corrected by the calibration
// offsets and saturated, and the calibration phase reached after the sample.
// Calibration counts off warmup_samples words, then averages roll and pitch
// over cal_samples consecutive still words (summed |rate| not above
// still_threshold; any moving word restarts the count), then holds the offsets
// until reset. The word that ends warmup and the word that completes the
// collection still carry uncorrected angles. The front end classifies each
// incoming word and pushes it into a QUEUE_DEPTH-deep queue, so input is
// taken while the back end works or a result waits at the output. The back
// end sequencer takes each word through pop, reciprocal multiply, remainder,
// correction and output load, and pops the next one only after that load,
// which waits while a result is held at the output; the word that completes
// calibration also waits for the 29-step serial offset divider. Configuration
// writes (index 0 warmup_samples, 1 cal_samples, 2 still_threshold, others
// ignored) take effect at once and are meant for when the block is idle.
module attitude_calibrate_and_smooth import acs_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // sample words in
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  // result words out
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [WARMUP_W-1:0] warmup_r;
  logic [CAL_W-1:0]    cal_r;
  logic [THRESH_W-1:0] thresh_r;
  phase_cfg_t          pcfg;

  logic                q_push, q_pop, q_full, q_empty;
  q_entry_t            q_in, q_out;

  // config registers; writes are masked to register width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warmup_r <= WARMUP_DEF;
      cal_r    <= CAL_DEF;
      thresh_r <= THRESH_DEF;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_WARMUP: warmup_r <= cfg_wdata[WARMUP_W-1:0];
        CFG_CAL:    cal_r    <= cfg_wdata[CAL_W-1:0];
        CFG_THRESH: thresh_r <= cfg_wdata[THRESH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign pcfg.warmup_samples = warmup_r;
  assign pcfg.cal_samples    = cal_r;

  // front: stillness classification at the input handshake
  acs_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .still_threshold (thresh_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_ent           (q_in)
  );

  // decoupling queue between front and back
  acs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_ent  (q_out),
    .empty    (q_empty)
  );

  // back: window, calibration, offsets, output register
  acs_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pcfg      (pcfg),
    .q_empty   (q_empty),
    .q_ent     (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for attitude_calibrate_and_smooth. Drives sample words,
// predicts each result word in-bench (phases, offsets, window means) and compares.
// Depends on acs_pkg and the RTL under rtl/.
module tb;
  import acs_pkg::*;

  localparam int WIN         = WINDOW_DEPTH_DEF;
  localparam int STALL_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int GAP_CAP     = 60;    // longest sender gap
  localparam int TAIL_CYCLES = 40;    // covers the offset divider on the last word

  // index with no register behind it; writes must be ignored
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  attitude_calibrate_and_smooth #(.WINDOW_DEPTH(WIN)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Bench copy of the block's state. Updated when a sample word is accepted,
  // so the result store always matches the order the block will answer in.
  // ---------------------------------------------------------------------------
  int      warmup_len  = 200;
  int      cal_len     = 100;
  int      still_limit = 80;
  phase_t  cal_state   = PH_WARMUP;
  int      sample_cnt  = 0;
  longint  roll_acc    = 0;
  longint  pitch_acc   = 0;
  int      roll_off    = 0;
  int      pitch_off   = 0;
  int      win_hist[WIN][3];
  int      win_sum[3];

  out_word_t pending_results[$];

  int errors        = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int restarts      = 0;  // still-run restarts caused by movement
  int blocked_words = 0;  // words that met in_ready low on first offer

  // idling knobs, percent per cycle
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;

  function automatic int clamp_angle(int v);
    if (v > ANGLE_LIMIT) return ANGLE_LIMIT;
    if (v < -ANGLE_LIMIT) return -ANGLE_LIMIT;
    return v;
  endfunction

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  // One sample word through the calibration and smoothing path.
  function automatic out_word_t predict_result(in_word_t w);
    out_word_t r;
    int ang[3];
    int gx, gy, gz, motion, croll, cpitch;
    gx = int'($signed(w.gyro_x));
    gy = int'($signed(w.gyro_y));
    gz = int'($signed(w.gyro_z));
    ang[0] = int'($signed(w.roll_in));
    ang[1] = int'($signed(w.pitch_in));
    ang[2] = int'($signed(w.yaw_in));

    // shift window: oldest out, newest in, running sums follow
    for (int a = 0; a < 3; a++) begin
      win_sum[a] -= win_hist[0][a];
      for (int i = 0; i < WIN - 1; i++) win_hist[i][a] = win_hist[i + 1][a];
      win_hist[WIN - 1][a] = ang[a];
      win_sum[a] += ang[a];
    end

    croll  = ang[0];
    cpitch = ang[1];
    case (cal_state)
      PH_WARMUP: begin
        sample_cnt = (sample_cnt + 1) & 16'hFFFF;
        if (sample_cnt >= warmup_len) begin
          cal_state  = PH_COLLECT;
          sample_cnt = 0;
        end
      end
      PH_COLLECT: begin
        motion = mag(gx) + mag(gy) + mag(gz);
        if (motion > still_limit) begin
          sample_cnt = 0;
          roll_acc   = 0;
          pitch_acc  = 0;
          restarts++;
        end else begin
          roll_acc   += ang[0];
          pitch_acc  += ang[1];
          sample_cnt = (sample_cnt + 1) & 16'hFFFF;
          if (sample_cnt >= cal_len && sample_cnt != 0) begin
            cal_state = PH_CAL;
            roll_off  = int'(roll_acc / sample_cnt);
            pitch_off = int'(pitch_acc / sample_cnt);
          end
        end
      end
      default: begin
        croll  = ang[0] - roll_off;
        cpitch = ang[1] - pitch_off;
      end
    endcase

    r.avg_roll        = 16'(clamp_angle(win_sum[0] / WIN));
    r.avg_pitch       = 16'(clamp_angle(win_sum[1] / WIN));
    r.avg_yaw         = 16'(clamp_angle(win_sum[2] / WIN));
    r.corrected_roll  = 16'(clamp_angle(croll));
    r.corrected_pitch = 16'(clamp_angle(cpitch));
    r.cal_phase       = cal_state;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_word_t make_word(int gx, int gy, int gz, int r, int p, int y);
    in_word_t w;
    w.gyro_x   = 16'(gx);
    w.gyro_y   = 16'(gy);
    w.gyro_z   = 16'(gz);
    w.roll_in  = 16'(r);
    w.pitch_in = 16'(p);
    w.yaw_in   = 16'(y);
    return w;
  endfunction

  function automatic int rand_signed(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  // mostly legal angles, some hugging +/-180 deg, some anything 16 bits allows
  function automatic int rand_angle();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return int'($signed(16'($urandom)));
    if (pick == 2) return (($urandom_range(0, 1) != 0) ? ANGLE_LIMIT : -ANGLE_LIMIT)
                          + rand_signed(40);
    return rand_signed(ANGLE_LIMIT);
  endfunction

  function automatic in_word_t rand_word();
    return make_word(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                     int'($signed(16'($urandom))), rand_angle(), rand_angle(),
                     rand_angle());
  endfunction

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Offer one word; entered and left at a falling edge. Valid is only dropped
  // when a gap is taken, so back-to-back words keep it high.
  task automatic send_word(in_word_t w);
    int  gap;
    bit  first;
    gap   = 0;
    first = 1'b1;
    while (gap < GAP_CAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    forever begin
      @(posedge clk);
      if (in_ready) break;
      if (first) blocked_words++;
      first = 1'b0;
    end
    pending_results.push_back(predict_result(w));
    words_sent++;
    @(negedge clk);
  endtask

  // Sender pause: nothing offered until every result word is back.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One register write; callers make sure the block is idle first.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_WARMUP: warmup_len  = int'(val[WARMUP_W-1:0]);
      CFG_CAL:    cal_len     = int'(val[CAL_W-1:0]);
      CFG_THRESH: still_limit = int'(val[THRESH_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted here on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with nothing outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("avg_roll",        want.avg_roll,        out_data.avg_roll);
        check_field("avg_pitch",       want.avg_pitch,       out_data.avg_pitch);
        check_field("avg_yaw",         want.avg_yaw,         out_data.avg_yaw);
        check_field("corrected_roll",  want.corrected_roll,  out_data.corrected_roll);
        check_field("corrected_pitch", want.corrected_pitch, out_data.corrected_pitch);
        check_field("cal_phase",       16'(want.cal_phase),  16'(out_data.cal_phase));
        results_seen++;
      end
    end
  end

  // Watchdog: any accepted word on either side restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
             STALL_LIMIT, pending_results.size());
    $display("attitude_calibrate_and_smooth verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Warmup held open; field extremes, out-of-range angles filling the window
  // (means must saturate), and negative sums truncating toward zero.
  task automatic test_field_extremes();
    set_idling(0, 0);
    write_reg(CFG_WARMUP, 17'd65535);
    write_reg(CFG_CAL, 17'd4096);
    write_reg(CFG_UNUSED, 17'($urandom));
    send_word(make_word(0, 0, 0, 0, 0, 0));
    send_word(make_word(32767, 32767, 32767, ANGLE_LIMIT, ANGLE_LIMIT, ANGLE_LIMIT));
    send_word(make_word(-32768, -32768, -32768, -ANGLE_LIMIT, -ANGLE_LIMIT,
                        -ANGLE_LIMIT));
    for (int i = 0; i < WIN; i++)
      send_word(make_word(i[0] ? 32767 : -32768, 0, 0, 32767, 32767, 32767));
    for (int i = 0; i < WIN; i++)
      send_word(make_word(0, i[0] ? -1 : 1, 0, -32768, -32768, -32768));
    send_word(make_word(1, -1, 0, 1, -1, 7));
  endtask

  // Warmup length rewritten mid-phase; bit 16 of the data must be dropped,
  // leaving 40. Random words until the still collection opens.
  task automatic test_warmup_exit();
    set_idling(87, 0);
    wait_drain();
    write_reg(CFG_WARMUP, 17'h1_0028);
    while (cal_state == PH_WARMUP) send_word(rand_word());
  endtask

  // Threshold edges (equal is still, one above restarts), both threshold
  // extremes, then random words straddling a mid threshold.
  task automatic test_still_detection();
    set_idling(0, 87);
    wait_drain();
    write_reg(CFG_THRESH, 17'd80);
    send_word(make_word(30, -30, 20, 100, -100, 5));
    send_word(make_word(30, -30, 21, 100, -100, 5));
    send_word(make_word(-32768, -32768, -32768, 200, 300, 0));
    wait_drain();
    write_reg(CFG_THRESH, 17'd98304);
    send_word(make_word(-32768, -32768, -32768, 200, 300, 0));
    send_word(make_word(32767, 32767, 32767, -200, -300, 0));
    wait_drain();
    write_reg(CFG_THRESH, 17'd0);
    send_word(make_word(0, 0, 0, 50, 60, 70));
    send_word(make_word(0, 0, 1, 50, 60, 70));
    send_word(make_word(0, -1, 0, 50, 60, 70));
    wait_drain();
    write_reg(CFG_THRESH, 17'd200);
    repeat (150) begin
      if ($urandom_range(0, 9) == 0) send_word(rand_word());
      else send_word(make_word(rand_signed(100), rand_signed(100), rand_signed(100),
                               rand_angle(), rand_angle(), rand_angle()));
    end
  endtask

  // Well-formed still runs around a random tilt with the odd jolt, then the
  // count target cut to one mid-phase so the next still word fixes offsets.
  task automatic test_offset_capture();
    int tilt_r, tilt_p;
    tilt_r = rand_signed(4000);
    tilt_p = rand_signed(4000);
    set_idling(14, 14);
    wait_drain();
    write_reg(CFG_THRESH, 17'd160);
    repeat (60) begin
      if ($urandom_range(0, 9) == 0)
        send_word(make_word(rand_signed(20000), rand_signed(20000), rand_signed(20000),
                            tilt_r + rand_signed(64), tilt_p + rand_signed(64),
                            rand_angle()));
      else
        send_word(make_word(rand_signed(50), rand_signed(50), rand_signed(50),
                            tilt_r + rand_signed(64), tilt_p + rand_signed(64),
                            rand_angle()));
    end
    wait_drain();
    write_reg(CFG_CAL, 17'd1);
    send_word(make_word(0, 0, 0, tilt_r, tilt_p, 0));
    if (cal_state != PH_CAL) begin
      $error("offset capture did not complete, phase %0d", cal_state);
      errors++;
    end
  endtask

  // Calibrated: corrected angles with saturation, register writes that must not
  // move the phase, all four idling patterns in turn.
  task automatic test_calibrated_random();
    int send_pct[4] = '{0, 87, 0, 14};
    int recv_pct[4] = '{0, 0, 87, 14};
    for (int c = 0; c < 4; c++) begin
      set_idling(send_pct[c], recv_pct[c]);
      wait_drain();
      write_reg(CFG_WARMUP, (c == 0) ? 17'd1 : 17'($urandom_range(1, 65535)));
      write_reg(CFG_CAL, 17'($urandom_range(1, 4096)));
      write_reg(CFG_THRESH, 17'($urandom_range(0, 98304)));
      repeat (95) send_word(rand_word());
    end
  endtask

  // Receiver holds off for a long stretch while words keep coming, so the
  // queue fills and in_ready drops; then everything is let out.
  task automatic test_receiver_hold();
    set_idling(0, 0);
    hold_req = 1'b1;
    repeat (12) send_word(rand_word());
    wait_drain();
  endtask

  initial begin
    for (int i = 0; i < WIN; i++)
      for (int a = 0; a < 3; a++) win_hist[i][a] = 0;
    for (int a = 0; a < 3; a++) win_sum[a] = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_field_extremes();
    test_warmup_exit();
    test_still_detection();
    test_offset_capture();
    test_calibrated_random();
    test_receiver_hold();

    wait_drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run: %0d sample words, %0d results compared, %0d still-run restarts,",
             words_sent, results_seen, restarts);
    $display("     %0d words held at the input, offsets roll %0d pitch %0d",
             blocked_words, roll_off, pitch_off);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("attitude_calibrate_and_smooth verification clean");
    end else begin
      $display("attitude_calibrate_and_smooth verification failed");
    end
    $finish;
  end

endmodule
